>>> rtl/gdr_pkg.sv
package gdr_pkg;

	localparam int MAP_SIDE       = 64;
	localparam int MAP_CELLS      = MAP_SIDE * MAP_SIDE;
	localparam int SCREEN_COLUMNS = 1024;
	localparam int MAX_STEPS      = 128;
	localparam int FRAC_BITS      = 8;

	localparam int CELL_W  = 6;
	localparam int COL_W   = 10;
	localparam int ANG_W   = 12;
	localparam int POS_W   = 14;
	localparam int FOV_W   = 11;
	localparam int DIST_W  = 16;
	localparam int FACE_W  = 2;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;

	localparam int Q14       = 14;
	localparam int TRIG_W    = 15;
	localparam int ONE_Q14   = 16384;
	localparam int QUARTER   = 1024;
	localparam int QS_C0     = 25736;
	localparam int QS_C1     = 10583;
	localparam int QS_C2     = 1306;
	localparam int QS_C3     = 77;
	localparam int DIST_MAX  = 65535;
	localparam int DIVD_W    = Q14 + FRAC_BITS + 1;
	localparam int DIVS_W    = TRIG_W;
	localparam int QDEPTH    = 2;

	localparam int ADDR_W    = 4;
	localparam int APB_W     = 32;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_CAST  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_POS_X = 2'd0,
		REG_POS_Y = 2'd1,
		REG_VIEW  = 2'd2,
		REG_FOV   = 2'd3
	} reg_idx_t;

	localparam logic [FACE_W-1:0] FACE_EAST  = 2'd0;
	localparam logic [FACE_W-1:0] FACE_WEST  = 2'd1;
	localparam logic [FACE_W-1:0] FACE_SOUTH = 2'd2;
	localparam logic [FACE_W-1:0] FACE_NORTH = 2'd3;

	typedef struct packed {
		cmd_t              cmd;
		logic [CELL_W-1:0] cell_x;
		logic [CELL_W-1:0] cell_y;
		logic              cell_is_wall;
		logic [COL_W-1:0]  column;
		logic [ANG_W-1:0]  angle;
	} item_t;

	typedef struct packed {
		logic clearing;
		logic idle;
	} back_stat_t;

endpackage

>>> rtl/gdr_front.sv
module gdr_front (
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [gdr_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                             s_tuser,
	input  logic [gdr_pkg::ANG_W-1:0]        view_angle,
	input  logic [gdr_pkg::FOV_W-1:0]        field_of_view,
	input  logic                             clearing,
	input  logic                             q_full,
	output logic                             push,
	output gdr_pkg::item_t                   item
);

	logic [gdr_pkg::FOV_W+gdr_pkg::COL_W-1:0] sweep;

	assign s_tready = !q_full && !clearing;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		item.cmd          = gdr_pkg::cmd_t'(s_tuser);
		item.cell_x       = s_tdata[5:0];
		item.cell_y       = s_tdata[11:6];
		item.cell_is_wall = s_tdata[12];
		item.column       = s_tdata[22:13];
		sweep = (gdr_pkg::FOV_W+gdr_pkg::COL_W)'(field_of_view)
			* (gdr_pkg::FOV_W+gdr_pkg::COL_W)'(item.column);
		item.angle = view_angle - gdr_pkg::ANG_W'(field_of_view >> 1)
			+ gdr_pkg::ANG_W'(sweep / gdr_pkg::SCREEN_COLUMNS);
	end

endmodule

>>> rtl/gdr_queue.sv
module gdr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gdr_pkg::item_t din,
	output logic           full,
	output logic           valid,
	input  logic           pop,
	output gdr_pkg::item_t dout
);

	localparam int PW = (gdr_pkg::QDEPTH > 1) ? $clog2(gdr_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(gdr_pkg::QDEPTH + 1);

	gdr_pkg::item_t  slot_q [gdr_pkg::QDEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;

	assign full  = cnt_q == CW'(gdr_pkg::QDEPTH);
	assign valid = cnt_q != '0;
	assign dout  = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(gdr_pkg::QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(gdr_pkg::QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= din;
		end
	end

endmodule

>>> rtl/gdr_div.sv
module gdr_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [gdr_pkg::DIVD_W-1:0]   dividend,
	input  logic [gdr_pkg::DIVS_W-1:0]   divisor,
	output logic                         done,
	output logic [gdr_pkg::DIVD_W-1:0]   quotient
);

	localparam int DW = gdr_pkg::DIVD_W;
	localparam int VW = gdr_pkg::DIVS_W;
	localparam int NW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [DW-1:0] quo_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          ge;

	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

endmodule

>>> rtl/gdr_back.sv
module gdr_back #(
	parameter int MAX_STEPS = gdr_pkg::MAX_STEPS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	input  gdr_pkg::item_t                   q_item,
	output logic                             q_pop,
	input  logic [gdr_pkg::POS_W-1:0]        player_pos_x,
	input  logic [gdr_pkg::POS_W-1:0]        player_pos_y,
	input  logic [gdr_pkg::ANG_W-1:0]        view_angle,
	output gdr_pkg::back_stat_t              stat,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [gdr_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tuser
);

	localparam int CW = $clog2(gdr_pkg::MAP_SIDE);
	localparam int AW = $clog2(gdr_pkg::MAP_CELLS);
	localparam int NW = $clog2(MAX_STEPS + 1);
	localparam int SW = gdr_pkg::DIST_W + $clog2(MAX_STEPS + 2);
	localparam int MB = gdr_pkg::DIST_W;
	localparam int PW = SW + MB;
	localparam int TW = gdr_pkg::TRIG_W;
	localparam int FB = gdr_pkg::FRAC_BITS;
	localparam int DW = gdr_pkg::DIST_W;
	localparam int AN = gdr_pkg::ANG_W;

	localparam logic [2:0] TS_SETUP = 3'd0;
	localparam logic [2:0] TS_Z2    = 3'd1;
	localparam logic [2:0] TS_T1    = 3'd2;
	localparam logic [2:0] TS_T2    = 3'd3;
	localparam logic [2:0] TS_T3    = 3'd4;
	localparam logic [2:0] TS_S     = 3'd5;

	localparam logic [1:0] K_COS    = 2'd0;
	localparam logic [1:0] K_SIN    = 2'd1;
	localparam logic [1:0] K_FISH   = 2'd2;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_TRIG  = 9'b000000010,
		ST_DIV   = 9'b000000100,
		ST_SIDE  = 9'b000001000,
		ST_WALK  = 9'b000010000,
		ST_TEST  = 9'b000100000,
		ST_SCALE = 9'b001000000,
		ST_EMIT  = 9'b010000000,
		ST_SPARE = 9'b100000000
	} state_t;

	state_t state_q;

	logic                       clearing_q;
	logic [AW-1:0]              clr_q;
	logic [1:0]                 k_q;
	logic [2:0]                 st_q;
	logic                       dsel_q;
	logic                       ssel_q;
	logic                       div_start_q;
	logic [NW-1:0]              n_q;
	logic                       out_valid_q;

	logic [gdr_pkg::COL_W-1:0]  column_q;
	logic [AN-1:0]              angle_q;
	logic [TW-1:0]              z_q;
	logic [TW-1:0]              z2_q;
	logic [TW-1:0]              t_q;
	logic                       negq_q;
	logic [TW-1:0]              magx_q;
	logic [TW-1:0]              magy_q;
	logic [TW-1:0]              cfm_q;
	logic                       negx_q;
	logic                       negy_q;
	logic                       cfpos_q;
	logic [DW-1:0]              ddx_q;
	logic [DW-1:0]              ddy_q;
	logic [SW-1:0]              sdx_q;
	logic [SW-1:0]              sdy_q;
	logic [SW-1:0]              perp_q;
	logic [CW:0]                mx_q;
	logic [CW:0]                my_q;
	logic                       side_q;
	logic [DW-1:0]              res_dist_q;
	logic [gdr_pkg::FACE_W-1:0] res_face_q;
	logic                       res_nohit_q;
	logic [gdr_pkg::COL_W-1:0]  out_col_q;
	logic [DW-1:0]              out_dist_q;
	logic [AN-1:0]              out_ang_q;
	logic [gdr_pkg::FACE_W-1:0] out_face_q;
	logic                       out_nohit_q;

	logic                       map_q [gdr_pkg::MAP_CELLS];
	logic                       rd_bit_q;

	logic [AN-1:0]              ang_sel;
	logic [10:0]                rr;
	logic [TW-1:0]              z_new;
	logic [TW-1:0]              s_val;
	logic [SW-1:0]              mul_a;
	logic [MB-1:0]              mul_b;
	logic [PW-1:0]              prod;
	logic [FB:0]                side_frac;
	logic [DW-1:0]              div_sat;
	logic                       div_done;
	logic [gdr_pkg::DIVD_W-1:0] div_quo;
	logic                       takex;
	logic [CW:0]                nmx;
	logic [CW:0]                nmy;
	logic                       step_out;
	logic [AW-1:0]              rd_addr;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic                       wr_bit;
	logic                       emit_load;
	logic                       last_step;

	assign q_pop     = q_valid && (state_q == ST_IDLE) && !clearing_q;
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || m_tready);
	assign last_step = n_q == NW'(MAX_STEPS);

	assign stat.clearing = clearing_q;
	assign stat.idle     = state_q == ST_IDLE;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_face_q, out_ang_q, out_dist_q, out_col_q};
	assign m_tuser  = out_nohit_q;

	always_comb begin
		case (k_q)
			K_COS:   ang_sel = angle_q + AN'(gdr_pkg::QUARTER);
			K_SIN:   ang_sel = angle_q;
			default: ang_sel = angle_q - view_angle + AN'(gdr_pkg::QUARTER);
		endcase
		rr    = ang_sel[10] ? 11'(gdr_pkg::QUARTER) - {1'b0, ang_sel[9:0]}
			: {1'b0, ang_sel[9:0]};
		z_new = {rr, 4'b0000};
	end

	always_comb begin
		side_frac = ssel_q
			? (negy_q ? {1'b0, player_pos_y[FB-1:0]} : (FB+1)'(1 << FB) - {1'b0, player_pos_y[FB-1:0]})
			: (negx_q ? {1'b0, player_pos_x[FB-1:0]} : (FB+1)'(1 << FB) - {1'b0, player_pos_x[FB-1:0]});
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_TRIG: begin
				case (st_q)
					TS_Z2: begin
						mul_a = SW'(z_q);
						mul_b = MB'(z_q);
					end
					TS_T1: begin
						mul_a = SW'(z2_q);
						mul_b = MB'(gdr_pkg::QS_C3);
					end
					TS_T2, TS_T3: begin
						mul_a = SW'(z2_q);
						mul_b = MB'(t_q);
					end
					TS_S: begin
						mul_a = SW'(z_q);
						mul_b = MB'(t_q);
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			ST_SIDE: begin
				mul_a = SW'(side_frac);
				mul_b = ssel_q ? ddy_q : ddx_q;
			end
			ST_SCALE: begin
				mul_a = perp_q;
				mul_b = MB'(cfm_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod  = PW'(mul_a) * PW'(mul_b);
		s_val = (prod[gdr_pkg::Q14 +: TW] > TW'(gdr_pkg::ONE_Q14))
			? TW'(gdr_pkg::ONE_Q14) : prod[gdr_pkg::Q14 +: TW];
	end

	assign div_sat = (div_quo > gdr_pkg::DIVD_W'(gdr_pkg::DIST_MAX))
		? DW'(gdr_pkg::DIST_MAX) : div_quo[DW-1:0];

	gdr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (gdr_pkg::DIVD_W'(1) << (gdr_pkg::Q14 + FB)),
		.divisor  (dsel_q ? magy_q : magx_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		takex    = sdx_q < sdy_q;
		nmx      = negx_q ? mx_q - 1'b1 : mx_q + 1'b1;
		nmy      = negy_q ? my_q - 1'b1 : my_q + 1'b1;
		step_out = takex ? nmx[CW] : nmy[CW];
		rd_addr  = takex ? {my_q[CW-1:0], nmx[CW-1:0]} : {nmy[CW-1:0], mx_q[CW-1:0]};
		wr_en    = clearing_q || (q_pop && q_item.cmd == gdr_pkg::CMD_WRITE);
		wr_addr  = clearing_q ? clr_q : {q_item.cell_y, q_item.cell_x};
		wr_bit   = !clearing_q && q_item.cell_is_wall;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_q[wr_addr] <= wr_bit;
		end
		rd_bit_q <= map_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clearing_q  <= 1'b1;
			clr_q       <= '0;
			k_q         <= K_COS;
			st_q        <= TS_SETUP;
			dsel_q      <= 1'b0;
			ssel_q      <= 1'b0;
			div_start_q <= 1'b0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == AW'(gdr_pkg::MAP_CELLS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && q_item.cmd == gdr_pkg::CMD_CAST) begin
						state_q <= ST_TRIG;
						k_q     <= K_COS;
						st_q    <= TS_SETUP;
					end
				end
				ST_TRIG: begin
					if (st_q == TS_S) begin
						st_q <= TS_SETUP;
						if (k_q == K_FISH) begin
							state_q     <= ST_DIV;
							dsel_q      <= 1'b0;
							div_start_q <= 1'b1;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end else begin
						st_q <= st_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (!dsel_q) begin
							dsel_q      <= 1'b1;
							div_start_q <= 1'b1;
						end else begin
							state_q <= ST_SIDE;
							ssel_q  <= 1'b0;
						end
					end
				end
				ST_SIDE: begin
					if (ssel_q) begin
						state_q <= ST_WALK;
						n_q     <= '0;
					end else begin
						ssel_q <= 1'b1;
					end
				end
				ST_WALK: begin
					n_q     <= n_q + 1'b1;
					state_q <= step_out ? ST_EMIT : ST_TEST;
				end
				ST_TEST: begin
					if (rd_bit_q) begin
						state_q <= ST_SCALE;
					end else if (last_step) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_SCALE: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					column_q <= q_item.column;
					angle_q  <= q_item.angle;
				end
			end
			ST_TRIG: begin
				case (st_q)
					TS_SETUP: begin
						z_q    <= z_new;
						negq_q <= ang_sel[11];
					end
					TS_Z2: z2_q <= prod[gdr_pkg::Q14 +: TW];
					TS_T1: t_q  <= TW'(gdr_pkg::QS_C2) - prod[gdr_pkg::Q14 +: TW];
					TS_T2: t_q  <= TW'(gdr_pkg::QS_C1) - prod[gdr_pkg::Q14 +: TW];
					TS_T3: t_q  <= TW'(gdr_pkg::QS_C0) - prod[gdr_pkg::Q14 +: TW];
					TS_S: begin
						case (k_q)
							K_COS: begin
								magx_q <= s_val;
								negx_q <= negq_q && (s_val != '0);
							end
							K_SIN: begin
								magy_q <= s_val;
								negy_q <= negq_q && (s_val != '0);
							end
							default: begin
								cfm_q   <= s_val;
								cfpos_q <= !negq_q;
							end
						endcase
					end
					default: begin
						z_q <= z_q;
					end
				endcase
			end
			ST_DIV: begin
				if (div_done) begin
					if (dsel_q) begin
						ddy_q <= div_sat;
					end else begin
						ddx_q <= div_sat;
					end
				end
			end
			ST_SIDE: begin
				if (ssel_q) begin
					sdy_q <= SW'(prod[FB +: DW]);
					mx_q  <= {1'b0, player_pos_x[gdr_pkg::POS_W-1:FB]};
					my_q  <= {1'b0, player_pos_y[gdr_pkg::POS_W-1:FB]};
				end else begin
					sdx_q <= SW'(prod[FB +: DW]);
				end
			end
			ST_WALK: begin
				if (takex) begin
					sdx_q  <= sdx_q + SW'(ddx_q);
					mx_q   <= nmx;
					side_q <= 1'b0;
				end else begin
					sdy_q  <= sdy_q + SW'(ddy_q);
					my_q   <= nmy;
					side_q <= 1'b1;
				end
				if (step_out) begin
					res_dist_q  <= DW'(gdr_pkg::DIST_MAX);
					res_face_q  <= gdr_pkg::FACE_EAST;
					res_nohit_q <= 1'b1;
				end
			end
			ST_TEST: begin
				perp_q <= side_q ? sdy_q - SW'(ddy_q) : sdx_q - SW'(ddx_q);
				if (!rd_bit_q && last_step) begin
					res_dist_q  <= DW'(gdr_pkg::DIST_MAX);
					res_face_q  <= gdr_pkg::FACE_EAST;
					res_nohit_q <= 1'b1;
				end
			end
			ST_SCALE: begin
				if (!cfpos_q) begin
					res_dist_q <= '0;
				end else if (prod[PW-1:gdr_pkg::Q14] > (PW-gdr_pkg::Q14)'(gdr_pkg::DIST_MAX)) begin
					res_dist_q <= DW'(gdr_pkg::DIST_MAX);
				end else begin
					res_dist_q <= prod[gdr_pkg::Q14 +: DW];
				end
				if (side_q) begin
					res_face_q <= negy_q ? gdr_pkg::FACE_SOUTH : gdr_pkg::FACE_NORTH;
				end else begin
					res_face_q <= negx_q ? gdr_pkg::FACE_EAST : gdr_pkg::FACE_WEST;
				end
				res_nohit_q <= 1'b0;
			end
			ST_EMIT: begin
				if (emit_load) begin
					out_col_q   <= column_q;
					out_dist_q  <= res_dist_q;
					out_ang_q   <= angle_q;
					out_face_q  <= res_face_q;
					out_nohit_q <= res_nohit_q;
				end
			end
			default: begin
				column_q <= column_q;
			end
		endcase
	end

endmodule

>>> rtl/grid_dda_raycaster.sv
// Grid ray caster over a 64 x 64 one-bit wall map.
// Items arrive on the s_ side; tuser selects a map write (0) or a ray cast (1).
// A map write gives no result. A cast gives one result transfer on the m_
// side with the column, distance, angle, face and no-hit flag. A cast takes
// at most MAX_STEPS grid steps. A cast that hits a wall passes through the
// queue, three quarter-wave sine evaluations on the shared multiplier, two
// reciprocal divisions, side setup, one map read per walk step, a scaling
// step and the load of the result register, in that order.
// Player position, view angle and field of view are set through the APB port;
// the user must set them only while the block is idle, which it does not enforce.
// A two-entry queue sits between the input side and the cast engine, and a
// result register sits on the output, so the next item is accepted while a
// finished result waits. A stalled receiver holds the engine once a second
// result is ready.
// After reset the map is cleared, one cell a cycle, over all 4096 cells;
// s_tready stays low during that pass.
module grid_dda_raycaster #(
	parameter int MAX_STEPS = gdr_pkg::MAX_STEPS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// cell_x [5:0], cell_y [11:6], cell_is_wall [12], column [22:13], zero [23]
	input  logic [gdr_pkg::IN_DATA_W-1:0]   s_tdata,
	// cmd [0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_column [9:0], wall_distance [25:10], ray_angle [37:26], wall_face [39:38]
	output logic [gdr_pkg::OUT_DATA_W-1:0]  m_tdata,
	// no_hit [0]
	output logic                            m_tuser,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [gdr_pkg::ADDR_W-1:0]      paddr,
	input  logic [gdr_pkg::APB_W-1:0]       pwdata,
	output logic [gdr_pkg::APB_W-1:0]       prdata,
	output logic                            pready
);

	logic [gdr_pkg::POS_W-1:0] pos_x_q;
	logic [gdr_pkg::POS_W-1:0] pos_y_q;
	logic [gdr_pkg::ANG_W-1:0] view_q;
	logic [gdr_pkg::FOV_W-1:0] fov_q;
	gdr_pkg::reg_idx_t         reg_idx;
	logic                      cfg_wr;

	gdr_pkg::item_t            push_item;
	gdr_pkg::item_t            q_item;
	logic                      q_push;
	logic                      q_full;
	logic                      q_valid;
	logic                      q_pop;
	gdr_pkg::back_stat_t       back_stat;

	assign pready  = 1'b1;
	assign reg_idx = gdr_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			gdr_pkg::REG_POS_X: prdata = gdr_pkg::APB_W'(pos_x_q);
			gdr_pkg::REG_POS_Y: prdata = gdr_pkg::APB_W'(pos_y_q);
			gdr_pkg::REG_VIEW:  prdata = gdr_pkg::APB_W'(view_q);
			gdr_pkg::REG_FOV:   prdata = gdr_pkg::APB_W'(fov_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			view_q  <= '0;
			fov_q   <= gdr_pkg::FOV_W'(683);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				gdr_pkg::REG_POS_X: pos_x_q <= pwdata[gdr_pkg::POS_W-1:0];
				gdr_pkg::REG_POS_Y: pos_y_q <= pwdata[gdr_pkg::POS_W-1:0];
				gdr_pkg::REG_VIEW:  view_q  <= pwdata[gdr_pkg::ANG_W-1:0];
				gdr_pkg::REG_FOV:   fov_q   <= pwdata[gdr_pkg::FOV_W-1:0];
				default:            fov_q   <= fov_q;
			endcase
		end
	end

	gdr_front u_front (
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.view_angle    (view_q),
		.field_of_view (fov_q),
		.clearing      (back_stat.clearing),
		.q_full        (q_full),
		.push          (q_push),
		.item          (push_item)
	);

	gdr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (push_item),
		.full   (q_full),
		.valid  (q_valid),
		.pop    (q_pop),
		.dout   (q_item)
	);

	gdr_back #(
		.MAX_STEPS (MAX_STEPS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.player_pos_x (pos_x_q),
		.player_pos_y (pos_y_q),
		.view_angle   (view_q),
		.stat         (back_stat),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser)
	);

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.clearing |-> !s_tready)
		else $error("input accepted during map clear");

	a_no_hit_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[25:10] == 16'hFFFF
		&& m_tdata[39:38] == gdr_pkg::FACE_EAST))
		else $error("no-hit result carries a distance or face");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> q_valid)
		else $error("queued item lost");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (back_stat.idle && !back_stat.clearing))
		else $error("queue popped while engine busy");

endmodule
